@@ rtl/beta_gamma_coincidence_histogrammer_core_assert.svh @@
// Assertion macros used by the histogram engine RTL (bgch_hist.sv).
`ifndef BETA_GAMMA_COINCIDENCE_HISTOGRAMMER_CORE_ASSERT_SVH
`define BETA_GAMMA_COINCIDENCE_HISTOGRAMMER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: whenever ante holds, cons holds too.
`define BGCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgch: same-cycle check failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define BGCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgch: next-cycle check failed");
`else
`define BGCH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BGCH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bgch_pkg.sv @@
// Shared constants and types of the beta-gamma coincidence histogrammer.
`timescale 1ns / 1ps
package bgch_pkg;

    localparam int ENERGY_W    = 16;
    localparam int ADDR_W      = 16;
    localparam int BIN_INDEX_W = 14;
    localparam int SEL_W       = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int SHIFT_W     = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Low four address bits that mark a beta detector.
    localparam logic [3:0] BETA_MARK = 4'd15;

    // Histogram codes.
    localparam logic [SEL_W-1:0] HIST_BETA    = 2'd0;
    localparam logic [SEL_W-1:0] HIST_SINGLES = 2'd1;
    localparam logic [SEL_W-1:0] HIST_ONLY    = 2'd2;
    localparam logic [SEL_W-1:0] HIST_NOBETA  = 2'd3;

    // Item action codes.
    localparam logic ACT_HIT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_EDGE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_SHIFT = 1'b1;

    // An event has closed and its buffered gammas must be walked.
    typedef struct packed {
        logic             valid;
        logic [SEL_W-1:0] other_sel;
    } close_t;

    // A bin read request taken from the input channel.
    typedef struct packed {
        logic                   req;
        logic [SEL_W-1:0]       sel;
        logic [BIN_INDEX_W-1:0] bin;
    } read_req_t;

endpackage

@@ rtl/bgch_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module bgch_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bgch_event.sv @@
// Event builder: classifies hits, buffers gamma energies and reports event closes.
`timescale 1ns / 1ps
module bgch_event #(
    parameter int MAX_HITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 hit_accept,
    input  logic [bgch_pkg::ADDR_W-1:0]          hit_address,
    input  logic [bgch_pkg::ENERGY_W-1:0]        hit_energy,
    input  logic                                 last_hit,
    output logic                                 buf_we,
    output logic [$clog2(MAX_HITS)-1:0]          buf_waddr,
    output logic [bgch_pkg::ENERGY_W-1:0]        buf_wdata,
    output bgch_pkg::close_t                     ev_close,
    output logic [$clog2(MAX_HITS+1)-1:0]        close_gamma_cnt,
    output logic                                 overflow_flag
);

    import bgch_pkg::*;

    localparam int GCNT_W = $clog2(MAX_HITS + 1);
    localparam int BUF_AW = $clog2(MAX_HITS);

    logic              seen_hit_reg;
    logic              beta_seen_reg;
    logic [GCNT_W-1:0] gamma_cnt_reg;
    logic              overflow_reg;

    logic              is_beta;
    logic              buf_full;
    logic              beta_after;
    logic [GCNT_W-1:0] gamma_after;

    assign is_beta     = (hit_address[3:0] == BETA_MARK);
    assign buf_full    = (gamma_cnt_reg == GCNT_W'(MAX_HITS));
    assign buf_we      = hit_accept && !is_beta && !buf_full;
    assign buf_waddr   = gamma_cnt_reg[BUF_AW-1:0];
    assign buf_wdata   = hit_energy;
    assign beta_after  = beta_seen_reg || is_beta;
    assign gamma_after = gamma_cnt_reg + GCNT_W'(buf_we);

    // Only one hit versus several matters, so a single flag tracks multiplicity.
    always_comb
    begin
        ev_close.valid = hit_accept && last_hit && (gamma_after != '0);
        if (!seen_hit_reg)
        begin
            ev_close.other_sel = HIST_ONLY;
        end
        else if (beta_after)
        begin
            ev_close.other_sel = HIST_BETA;
        end
        else
        begin
            ev_close.other_sel = HIST_NOBETA;
        end
    end

    assign close_gamma_cnt = gamma_after;
    assign overflow_flag   = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_hit_reg  <= 1'b0;
            beta_seen_reg <= 1'b0;
            gamma_cnt_reg <= '0;
            overflow_reg  <= 1'b0;
        end
        else if (hit_accept)
        begin
            if (!is_beta && buf_full)
            begin
                overflow_reg <= 1'b1;
            end
            if (last_hit)
            begin
                seen_hit_reg  <= 1'b0;
                beta_seen_reg <= 1'b0;
                gamma_cnt_reg <= '0;
            end
            else
            begin
                seen_hit_reg  <= 1'b1;
                beta_seen_reg <= beta_after;
                gamma_cnt_reg <= gamma_after;
            end
        end
    end

endmodule

@@ rtl/bgch_hist.sv @@
// Histogram engine: clearing pass, event walk with read-modify-write, and bin reads.
`timescale 1ns / 1ps
`include "beta_gamma_coincidence_histogrammer_core_assert.svh"
module bgch_hist #(
    parameter int NUM_BINS   = 16384,
    parameter int MAX_HITS   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [bgch_pkg::ENERGY_W-1:0]        low_edge,
    input  logic [bgch_pkg::SHIFT_W-1:0]         bin_shift,
    input  bgch_pkg::close_t                     ev_close,
    input  logic [$clog2(MAX_HITS+1)-1:0]        close_gamma_cnt,
    input  bgch_pkg::read_req_t                  rd_req,
    input  logic                                 overflow_flag,
    output logic                                 buf_re,
    output logic [$clog2(MAX_HITS)-1:0]          buf_raddr,
    input  logic [bgch_pkg::ENERGY_W-1:0]        buf_rdata,
    output logic                                 busy,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bgch_pkg::OUT_COUNT_W-1:0]     bin_count,
    output logic                                 overflow_seen
);

    import bgch_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int HAW    = BIN_W + SEL_W;
    localparam int GCNT_W = $clog2(MAX_HITS + 1);
    localparam int BUF_AW = $clog2(MAX_HITS);
    localparam int CMP_W  = ENERGY_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_WA    = 3'd5;

    logic [2:0]        state_reg,     state_next;
    logic [HAW-1:0]    clr_addr_reg,  clr_addr_next;
    logic [GCNT_W-1:0] walk_cnt_reg,  walk_cnt_next;
    logic [GCNT_W-1:0] rd_idx_reg,    rd_idx_next;
    logic [SEL_W-1:0]  other_sel_reg, other_sel_next;
    logic              more_reg,      more_next;
    logic              first_reg,     first_next;
    logic [BIN_W-1:0]  cur_bin_reg,   cur_bin_next;
    logic              cur_ok_reg,    cur_ok_next;
    logic              rd_oor_reg,    rd_oor_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_COUNT_W-1:0] bin_count_reg;
    logic              overflow_seen_reg;

    logic                  hist_we;
    logic [HAW-1:0]        hist_waddr;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic                  hist_re;
    logic [HAW-1:0]        hist_raddr;
    logic [COUNT_BITS-1:0] hist_rdata;
    logic [COUNT_BITS-1:0] hist_inc;
    logic [OUT_COUNT_W-1:0] count_sat;
    logic                  load_out;

    logic [CMP_W-1:0]    diff;
    logic [ENERGY_W-1:0] shifted;
    logic                new_ok;
    logic [ENERGY_W-1:0] req_bin;
    logic                req_in_range;

    bgch_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (1 << HAW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Bin of the gamma energy coming out of the event buffer.
    assign diff    = {1'b0, buf_rdata} - {1'b0, low_edge};
    assign shifted = diff[ENERGY_W-1:0] >> bin_shift;
    assign new_ok  = !diff[ENERGY_W] && ({1'b0, shifted} < CMP_W'(NUM_BINS));

    assign req_bin      = ENERGY_W'(rd_req.bin);
    assign req_in_range = ({1'b0, req_bin} < CMP_W'(NUM_BINS));

    // Saturating increment of the count just read.
    assign hist_inc = (&hist_rdata) ? hist_rdata : hist_rdata + COUNT_BITS'(1);

    generate
        if (COUNT_BITS > OUT_COUNT_W)
        begin : g_sat
            assign count_sat = (|hist_rdata[COUNT_BITS-1:OUT_COUNT_W])
                             ? {OUT_COUNT_W{1'b1}} : hist_rdata[OUT_COUNT_W-1:0];
        end
        else
        begin : g_ext
            assign count_sat = OUT_COUNT_W'(hist_rdata);
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        walk_cnt_next  = walk_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        other_sel_next = other_sel_reg;
        more_next      = more_reg;
        first_next     = first_reg;
        cur_bin_next   = cur_bin_reg;
        cur_ok_next    = cur_ok_reg;
        rd_oor_next    = rd_oor_reg;
        load_out       = 1'b0;
        hist_we        = 1'b0;
        hist_waddr     = '0;
        hist_wdata     = hist_inc;
        hist_re        = 1'b0;
        hist_raddr     = '0;
        buf_re         = 1'b0;
        buf_raddr      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                hist_we       = 1'b1;
                hist_waddr    = clr_addr_reg;
                hist_wdata    = '0;
                clr_addr_next = clr_addr_reg + HAW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ev_close.valid)
                begin
                    walk_cnt_next  = close_gamma_cnt;
                    other_sel_next = ev_close.other_sel;
                    state_next     = ST_FETCH;
                end
                else if (rd_req.req)
                begin
                    hist_re     = 1'b1;
                    hist_raddr  = {rd_req.sel, req_bin[BIN_W-1:0]};
                    rd_oor_next = !req_in_range;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                buf_re      = 1'b1;
                buf_raddr   = '0;
                rd_idx_next = GCNT_W'(1);
                more_next   = 1'b1;
                first_next  = 1'b1;
                state_next  = ST_WB;
            end
            ST_WB:
            begin
                // Finish the other histogram of the previous gamma, start the next one.
                hist_we    = cur_ok_reg && !first_reg;
                hist_waddr = {other_sel_reg, cur_bin_reg};
                if (more_reg)
                begin
                    cur_bin_next = shifted[BIN_W-1:0];
                    cur_ok_next  = new_ok;
                    hist_re      = 1'b1;
                    hist_raddr   = {HIST_SINGLES, shifted[BIN_W-1:0]};
                    first_next   = 1'b0;
                    state_next   = ST_WA;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WA:
            begin
                hist_we    = cur_ok_reg;
                hist_waddr = {HIST_SINGLES, cur_bin_reg};
                hist_re    = 1'b1;
                hist_raddr = {other_sel_reg, cur_bin_reg};
                if (rd_idx_reg < walk_cnt_reg)
                begin
                    buf_re      = 1'b1;
                    buf_raddr   = rd_idx_reg[BUF_AW-1:0];
                    rd_idx_next = rd_idx_reg + GCNT_W'(1);
                    more_next   = 1'b1;
                end
                else
                begin
                    more_next = 1'b0;
                end
                state_next = ST_WB;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            walk_cnt_reg  <= '0;
            rd_idx_reg    <= '0;
            other_sel_reg <= HIST_ONLY;
            more_reg      <= 1'b0;
            first_reg     <= 1'b0;
            cur_ok_reg    <= 1'b0;
            rd_oor_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            walk_cnt_reg  <= walk_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            other_sel_reg <= other_sel_next;
            more_reg      <= more_next;
            first_reg     <= first_next;
            cur_ok_reg    <= cur_ok_next;
            rd_oor_reg    <= rd_oor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bin_reg <= cur_bin_next;
        if (load_out)
        begin
            bin_count_reg     <= rd_oor_reg ? '0 : count_sat;
            overflow_seen_reg <= overflow_flag;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign bin_count     = bin_count_reg;
    assign overflow_seen = overflow_seen_reg;

    // The walk never writes the entry it reads in the same cycle.
    `BGCH_ASSERT_IMP(a_no_rw_clash, clk, rst_n, hist_we && hist_re, hist_waddr != hist_raddr)
    // A walk starts only for an event that buffered at least one gamma.
    `BGCH_ASSERT_IMP(a_walk_nonempty, clk, rst_n, state_reg == ST_FETCH, walk_cnt_reg != '0)
    // The buffer read index stays inside the event being walked.
    `BGCH_ASSERT_IMP(a_idx_bound, clk, rst_n, state_reg == ST_WA || state_reg == ST_WB,
                     rd_idx_reg <= walk_cnt_reg)
    // A read whose result has room shows the result in the next cycle.
    `BGCH_ASSERT_NXT(a_read_delivers, clk, rst_n,
                     state_reg == ST_READ && !(out_valid_reg && out_stall), out_valid_reg)

endmodule

@@ rtl/beta_gamma_coincidence_histogrammer_core.sv @@
// Top level of the beta-gamma coincidence histogrammer.
//
//   Channel  Direction  Handshake                Payload
//   -------  ---------  -----------------------  ------------------------------------------
//   in       sink       in_valid / in_stall      action, hit_address, hit_energy, last_hit,
//                                                histogram_select, bin_index
//   out      source     out_valid / out_stall    bin_count, overflow_seen
//   cfg      sink       cfg_write_en             cfg_index, cfg_data
//
// A hit that does not close an event holding buffered gammas is taken without a stall.
// A closing hit of such an event keeps the input stalled while those gammas are walked:
// each gamma needs two histogram read-modify-writes and the histogram RAM has one read
// and one write port. A read item keeps the input stalled until its result is loaded
// into the output register. After reset all 4 * 2**ceil(log2(NUM_BINS)) histogram RAM
// entries (65536 with the defaults) are swept to zero with the input stalled; configuration writes are taken anyway.
`timescale 1ns / 1ps
module beta_gamma_coincidence_histogrammer_core #(
    parameter int NUM_BINS   = 16384,
    parameter int MAX_HITS   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input item channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [bgch_pkg::ADDR_W-1:0]          hit_address,
    input  logic [bgch_pkg::ENERGY_W-1:0]        hit_energy,
    input  logic                                 last_hit,
    input  logic [bgch_pkg::SEL_W-1:0]           histogram_select,
    input  logic [bgch_pkg::BIN_INDEX_W-1:0]     bin_index,
    // Result item channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bgch_pkg::OUT_COUNT_W-1:0]     bin_count,
    output logic                                 overflow_seen,
    // Configuration write port.
    input  logic                                 cfg_write_en,
    input  logic [bgch_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bgch_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import bgch_pkg::*;

    localparam int GCNT_W = $clog2(MAX_HITS + 1);
    localparam int BUF_AW = $clog2(MAX_HITS);

    logic [ENERGY_W-1:0] low_edge_reg;
    logic [SHIFT_W-1:0]  bin_shift_reg;

    logic                in_accept;
    logic                hit_accept;
    logic                busy;
    read_req_t           rd_req;
    close_t              ev_close;
    logic [GCNT_W-1:0]   close_gamma_cnt;
    logic                overflow_flag;

    logic                buf_we;
    logic [BUF_AW-1:0]   buf_waddr;
    logic [ENERGY_W-1:0] buf_wdata;
    logic                buf_re;
    logic [BUF_AW-1:0]   buf_raddr;
    logic [ENERGY_W-1:0] buf_rdata;

    // Items are taken only while the histogram engine is idle, so an event close
    // and a bin read never meet a walk or a clearing pass in progress.
    assign in_stall   = busy;
    assign in_accept  = in_valid && !in_stall;
    assign hit_accept = in_accept && (action == ACT_HIT);

    assign rd_req.req = in_accept && (action == ACT_READ);
    assign rd_req.sel = histogram_select;
    assign rd_req.bin = bin_index;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg  <= '0;
            bin_shift_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_LOW_EDGE:  low_edge_reg  <= cfg_data[ENERGY_W-1:0];
                REG_BIN_SHIFT: bin_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Gathers hits, sorts betas from gammas and writes gamma energies to the buffer.
    bgch_event #(
        .MAX_HITS (MAX_HITS)
    ) u_event (
        .clk             (clk),
        .rst_n           (rst_n),
        .hit_accept      (hit_accept),
        .hit_address     (hit_address),
        .hit_energy      (hit_energy),
        .last_hit        (last_hit),
        .buf_we          (buf_we),
        .buf_waddr       (buf_waddr),
        .buf_wdata       (buf_wdata),
        .ev_close        (ev_close),
        .close_gamma_cnt (close_gamma_cnt),
        .overflow_flag   (overflow_flag)
    );

    // Gamma energies of the open event; entries past the fill count are never read.
    bgch_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (MAX_HITS)
    ) u_gamma_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Histogram RAM, event walk, bin reads and the output register.
    bgch_hist #(
        .NUM_BINS   (NUM_BINS),
        .MAX_HITS   (MAX_HITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .clk             (clk),
        .rst_n           (rst_n),
        .low_edge        (low_edge_reg),
        .bin_shift       (bin_shift_reg),
        .ev_close        (ev_close),
        .close_gamma_cnt (close_gamma_cnt),
        .rd_req          (rd_req),
        .overflow_flag   (overflow_flag),
        .buf_re          (buf_re),
        .buf_raddr       (buf_raddr),
        .buf_rdata       (buf_rdata),
        .busy            (busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bin_count       (bin_count),
        .overflow_seen   (overflow_seen)
    );

endmodule

@@ tb/sv/bgch_histogram_checker.sv @@
// Checker for the histogrammer: predicts bin reads from watched traffic and compares results.
`timescale 1ns / 1ps
module bgch_histogram_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               action,
    input  logic [bgch_pkg::ADDR_W-1:0]        hit_address,
    input  logic [bgch_pkg::ENERGY_W-1:0]      hit_energy,
    input  logic                               last_hit,
    input  logic [bgch_pkg::SEL_W-1:0]         histogram_select,
    input  logic [bgch_pkg::BIN_INDEX_W-1:0]   bin_index,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [bgch_pkg::OUT_COUNT_W-1:0]   bin_count,
    input  logic                               overflow_seen,
    input  logic                               cfg_write_en,
    input  logic [bgch_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgch_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 pending_results,
    output int                                 fail_count,
    output int                                 checked_results
);
    import bgch_pkg::*;

    localparam int NUM_BINS     = 16384;
    localparam int MAX_HITS     = 64;
    localparam int HIT_CAP      = 127;
    localparam int STORE_DEPTH  = 4 * NUM_BINS;
    localparam logic [OUT_COUNT_W-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] count;
        logic                   overflow;
    } bin_read_t;

    logic [OUT_COUNT_W-1:0] bin_counts [0:STORE_DEPTH-1];
    logic [ENERGY_W-1:0]    gamma_energies [0:MAX_HITS-1];
    int                     hits_in_event;
    int                     gammas_in_event;
    logic                   beta_in_event;
    logic                   overflow_flag;
    logic [ENERGY_W-1:0]    low_edge_q;
    logic [SHIFT_W-1:0]     shift_q;
    bin_read_t              expected_reads [$];
    int                     fails;
    int                     checked;

    // Energy to bin with the current binning; out-of-range energies are dropped.
    function automatic void count_energy(input logic [SEL_W-1:0] sel,
                                         input logic [ENERGY_W-1:0] energy);
        logic [31:0] offset;
        logic [31:0] bin;
        if (energy >= low_edge_q)
        begin
            offset = 32'(energy) - 32'(low_edge_q);
            bin    = offset >> shift_q;
            if (bin < NUM_BINS)
            begin
                if (bin_counts[{sel, bin[BIN_INDEX_W-1:0]}] != COUNT_FULL)
                    bin_counts[{sel, bin[BIN_INDEX_W-1:0]}] += 1'b1;
            end
        end
    endfunction

    function automatic void tally_closed_event();
        logic [SEL_W-1:0] other;
        if (hits_in_event <= 1)
            other = HIST_ONLY;
        else if (beta_in_event)
            other = HIST_BETA;
        else
            other = HIST_NOBETA;
        for (int k = 0; k < gammas_in_event; k++)
        begin
            count_energy(HIST_SINGLES, gamma_energies[k]);
            count_energy(other, gamma_energies[k]);
        end
        hits_in_event   = 0;
        gammas_in_event = 0;
        beta_in_event   = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bin_read_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                bin_counts[i] = '0;
            hits_in_event   = 0;
            gammas_in_event = 0;
            beta_in_event   = 1'b0;
            overflow_flag   = 1'b0;
            low_edge_q      = '0;
            shift_q         = '0;
            expected_reads.delete();
            fails           = 0;
            checked         = 0;
            pending_results <= 0;
            fail_count      <= 0;
            checked_results <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_LOW_EDGE)
                    low_edge_q = cfg_data;
                else if (cfg_index == REG_BIN_SHIFT)
                    shift_q = cfg_data[SHIFT_W-1:0];
            end

            // Results are retired before new reads are queued on the same edge.
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_reads.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("bin read result with none expected: count=%0d overflow=%0b",
                                 bin_count, overflow_seen);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (bin_count !== want.count || overflow_seen !== want.overflow)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("bin read mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                                     want.count, bin_count, want.overflow, overflow_seen);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (action == ACT_HIT)
                begin
                    if (hits_in_event < HIT_CAP)
                        hits_in_event++;
                    if (hit_address[3:0] == BETA_MARK)
                        beta_in_event = 1'b1;
                    else if (gammas_in_event < MAX_HITS)
                    begin
                        gamma_energies[gammas_in_event] = hit_energy;
                        gammas_in_event++;
                    end
                    else
                        overflow_flag = 1'b1;
                    if (last_hit)
                        tally_closed_event();
                end
                else
                begin
                    want.count    = bin_counts[{histogram_select, bin_index}];
                    want.overflow = overflow_flag;
                    expected_reads.push_back(want);
                end
            end

            pending_results <= expected_reads.size();
            fail_count      <= fails;
            checked_results <= checked;
        end
    end

endmodule

@@ tb/sv/tb_beta_gamma_coincidence_histogrammer_core.sv @@
// Testbench top for the histogrammer: drives hits, bin reads and binning settings.
`timescale 1ns / 1ps
module tb_beta_gamma_coincidence_histogrammer_core;
    import bgch_pkg::*;

    // Clock and the single reset at the start of the run.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every block input starts at a known value.
    logic                   in_valid         = 1'b0;
    logic                   in_stall;
    logic                   action           = ACT_HIT;
    logic [ADDR_W-1:0]      hit_address      = '0;
    logic [ENERGY_W-1:0]    hit_energy       = '0;
    logic                   last_hit         = 1'b0;
    logic [SEL_W-1:0]       histogram_select = HIST_BETA;
    logic [BIN_INDEX_W-1:0] bin_index        = '0;
    logic                   out_valid;
    logic                   out_stall        = 1'b0;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic                   overflow_seen;
    logic                   cfg_write_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index        = REG_LOW_EDGE;
    logic [CFG_DATA_W-1:0]  cfg_data         = '0;

    int pending_results;
    int fail_count;
    int checked_results;

    // Stimulus bookkeeping. The binning copy lets hits land in bins that reads then target.
    int cur_low        = 0;
    int cur_shift      = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int n_items        = 0;
    int n_hits         = 0;
    int n_reads        = 0;
    int n_events       = 0;
    int n_settings     = 0;

    // Idle mix per phase: receiver-heavy gaps first, then sender-heavy, then none.
    int send_idle_tab [3] = '{26, 51, 0};
    int recv_idle_tab [3] = '{51, 26, 0};

    // Binning settings: defaults, the extremes of both registers, and a random one at the end.
    // The shift word with all upper bits set checks that only the low four bits count.
    logic [15:0] low_tab   [6] = '{16'd0, 16'd65535, 16'd1000, 16'd0, 16'd40000, 16'd0};
    logic [15:0] shift_tab [6] = '{16'd0, 16'd0, 16'd3, 16'd8, 16'hFFFF, 16'd0};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    beta_gamma_coincidence_histogrammer_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .hit_address      (hit_address),
        .hit_energy       (hit_energy),
        .last_hit         (last_hit),
        .histogram_select (histogram_select),
        .bin_index        (bin_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_count        (bin_count),
        .overflow_seen    (overflow_seen),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    bgch_histogram_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .hit_address      (hit_address),
        .hit_energy       (hit_energy),
        .last_hit         (last_hit),
        .histogram_select (histogram_select),
        .bin_index        (bin_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bin_count        (bin_count),
        .overflow_seen    (overflow_seen),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pending_results  (pending_results),
        .fail_count       (fail_count),
        .checked_results  (checked_results)
    );

    // The result side stalls at random; the rate follows the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offers one item and returns at the edge where it is taken. The valid is left high so
    // that a following item can go out back to back; a gap, if drawn, lowers it first.
    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic [ENERGY_W-1:0] energy, input logic last,
                             input logic [SEL_W-1:0] sel, input logic [BIN_INDEX_W-1:0] bin);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid         <= 1'b1;
        action           <= act;
        hit_address      <= addr;
        hit_energy       <= energy;
        last_hit         <= last;
        histogram_select <= sel;
        bin_index        <= bin;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n_items++;
        if (act == ACT_HIT)
        begin
            n_hits++;
            if (last)
                n_events++;
        end
        else
            n_reads++;
    endtask

    // A hit with a random address of the wanted kind; the read-only fields carry noise.
    task automatic send_hit(input logic is_beta, input logic [ENERGY_W-1:0] energy,
                            input logic last);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'($urandom_range(65535));
        if (is_beta)
            addr[3:0] = BETA_MARK;
        else if (addr[3:0] == BETA_MARK)
            addr[3:0] = 4'($urandom_range(14));
        send_item(ACT_HIT, addr, energy, last, SEL_W'($urandom_range(3)),
                  BIN_INDEX_W'($urandom_range(16383)));
    endtask

    // A bin read; the hit-only fields carry noise.
    task automatic send_read(input logic [SEL_W-1:0] sel, input logic [BIN_INDEX_W-1:0] bin);
        send_item(ACT_READ, ADDR_W'($urandom), ENERGY_W'($urandom), 1'($urandom), sel, bin);
    endtask

    // Mostly energies that fall in a few low bins, now and then the last bin or just past
    // it, and now and then any energy at all (which covers energies below the low edge).
    function automatic logic [ENERGY_W-1:0] pick_energy();
        int k;
        int e;
        if ($urandom_range(9) == 0)
            return ENERGY_W'($urandom_range(65535));
        if ($urandom_range(19) == 0)
            k = 16383 + int'($urandom_range(1));
        else
            k = int'($urandom_range(7));
        e = cur_low + (k << cur_shift) + int'($urandom & ((32'd1 << cur_shift) - 1));
        if (e > 65535)
            e = int'($urandom_range(65535));
        return ENERGY_W'(e);
    endfunction

    // Reads aimed at the bins that pick_energy favors, so counts above zero get compared.
    function automatic logic [BIN_INDEX_W-1:0] pick_bin();
        if ($urandom_range(9) == 0)
            return BIN_INDEX_W'(16383);
        return BIN_INDEX_W'($urandom_range(7));
    endfunction

    task automatic aimed_read();
        send_read(SEL_W'($urandom_range(3)), pick_bin());
    endtask

    // One well-formed event: random gammas and betas, the last one closing it. A read may
    // slip in between hits, which must not see the still-open event.
    task automatic run_event(input int hits);
        for (int h = 0; h < hits; h++)
        begin
            if (h > 0 && $urandom_range(9) == 0)
                aimed_read();
            send_hit($urandom_range(3) == 0, pick_energy(), h == hits - 1);
        end
    endtask

    // Holds the sender off until every read has been answered.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Writes both binning registers once the block is quiet. The extra cycles cover an
    // event walk that could still be running behind the last answered read.
    task automatic apply_binning(input logic [15:0] low, input logic [15:0] shift_word);
        wait_until_idle();
        repeat (200) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_LOW_EDGE;
        cfg_data     <= low;
        @(posedge clk);
        cfg_index    <= REG_BIN_SHIFT;
        cfg_data     <= shift_word;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_low   = int'(low);
        cur_shift = int'(shift_word[3:0]);
        n_settings++;
    endtask

    // One event longer than the hit buffer and past the hit-count ceiling: 66 gammas then
    // 64 betas. Two gammas are dropped, the sticky overflow flag rises, and the buffered
    // gammas go to the beta-gated histogram.
    task automatic overflow_event();
        for (int h = 0; h < 130; h++)
            send_hit(h >= 66, pick_energy(), h == 129);
        aimed_read();
        send_read(HIST_BETA, BIN_INDEX_W'(0));
    endtask

    // Random traffic: mostly complete events with reads after them, plus reads alone,
    // raw noise that may leave an event open or split one, and occasional full drains.
    task automatic random_segment(input int items);
        int start;
        int r;
        start = n_items;
        while (n_items - start < items)
        begin
            r = int'($urandom_range(99));
            if (r < 65)
            begin
                run_event(($urandom_range(3) == 0) ? 1 : int'($urandom_range(6, 2)));
                if ($urandom_range(1) == 0)
                begin
                    aimed_read();
                    if ($urandom_range(1) == 0)
                        aimed_read();
                end
            end
            else if (r < 85)
            begin
                if ($urandom_range(3) == 0)
                    send_read(SEL_W'($urandom_range(3)), BIN_INDEX_W'($urandom_range(16383)));
                else
                    aimed_read();
            end
            else if (r < 95)
                send_item(1'($urandom), ADDR_W'($urandom), ENERGY_W'($urandom), 1'($urandom),
                          SEL_W'($urandom), BIN_INDEX_W'($urandom));
            else
                wait_until_idle();
        end
        // Close whatever noise left open and finish on a read, so the block is idle
        // once that read has been answered.
        send_hit(1'b0, pick_energy(), 1'b1);
        aimed_read();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset binning (low edge 0, one energy unit per bin).
        // The block sweeps its histogram memory first; the first item simply waits for it.
        send_idle_pct = send_idle_tab[0];
        recv_idle_pct = recv_idle_tab[0];
        // One-hit events: lowest energy into bin 0, the last bin from the top gamma address.
        send_item(ACT_HIT, 16'h0000, 16'd0, 1'b1, HIST_BETA, '0);
        send_item(ACT_HIT, 16'hFFFE, 16'd16383, 1'b1, HIST_NOBETA, '1);
        // Beta plus gamma: the gamma goes to the beta-gated histogram.
        send_item(ACT_HIT, 16'hFFFF, 16'hFFFF, 1'b0, HIST_SINGLES, '1);
        send_item(ACT_HIT, 16'h0000, 16'd5, 1'b1, HIST_ONLY, '0);
        // Three gammas, no beta: two of them lie beyond the last bin and are dropped.
        send_item(ACT_HIT, 16'h1230, 16'd5, 1'b0, HIST_BETA, '0);
        send_item(ACT_HIT, 16'h4567, 16'hFFFF, 1'b0, HIST_BETA, '0);
        send_item(ACT_HIT, 16'h89AE, 16'd16384, 1'b1, HIST_BETA, '0);
        // An event of a beta alone counts nothing.
        send_item(ACT_HIT, 16'h000F, 16'd7, 1'b1, HIST_BETA, '0);
        // A read in the middle of an event sees the histograms without it.
        send_item(ACT_HIT, 16'h7771, 16'd7, 1'b0, HIST_BETA, '0);
        send_read(HIST_SINGLES, BIN_INDEX_W'(7));
        send_item(ACT_HIT, 16'h7772, 16'd7, 1'b1, HIST_BETA, '0);
        // Read back every histogram where the events above should have left counts.
        send_read(HIST_ONLY, BIN_INDEX_W'(0));
        send_read(HIST_ONLY, BIN_INDEX_W'(16383));
        send_read(HIST_SINGLES, BIN_INDEX_W'(0));
        send_read(HIST_SINGLES, BIN_INDEX_W'(5));
        send_read(HIST_BETA, BIN_INDEX_W'(5));
        send_read(HIST_NOBETA, BIN_INDEX_W'(5));
        send_read(HIST_NOBETA, BIN_INDEX_W'(7));
        send_read(HIST_SINGLES, BIN_INDEX_W'(7));
        send_read(HIST_SINGLES, BIN_INDEX_W'(16383));
        send_read(HIST_BETA, BIN_INDEX_W'(16383));

        // Random part: three idle phases, each with two binning settings.
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = send_idle_tab[p];
            recv_idle_pct = recv_idle_tab[p];
            for (int s = 0; s < 2; s++)
            begin
                if (2 * p + s == 5)
                    apply_binning(16'($urandom_range(20000)), 16'($urandom_range(8)));
                else
                    apply_binning(low_tab[2 * p + s], shift_tab[2 * p + s]);
                if (2 * p + s == 2)
                    overflow_event();
                random_segment(200);
            end
        end

        // Drain, then leave room for any stray result before the verdict.
        wait_until_idle();
        repeat (200) @(posedge clk);

        $display("Covered %0d hits in %0d closed events and %0d bin reads over %0d binnings.",
                 n_hits, n_events, n_reads, n_settings);
        $display("Bin read results compared: %0d, mismatching: %0d.",
                 checked_results, fail_count);
        if (fail_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hang: far beyond the reset sweep plus the slowest run.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
